@@ hdl/mrtb_pkg.sv @@
// types, constants and a helper function shared by the timer bank modules
// no dependencies

package mrtb_pkg;

    localparam int NUM_TIMERS = 8;
    localparam int TIMER_W    = 8;
    localparam int IDX_W      = $clog2(NUM_TIMERS);

    localparam logic [7:0] LED_DIVIDE_RESET = 8'd78;

    // command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // phase bits that pick a tick group, lowest set bit wins
    localparam logic [7:0] PH_BIT0 = 8'h01;
    localparam logic [7:0] PH_BIT1 = 8'h02;
    localparam logic [7:0] PH_BIT2 = 8'h04;
    localparam logic [7:0] PH_BIT3 = 8'h08;
    localparam logic [7:0] PH_BIT4 = 8'h10;
    localparam logic [7:0] PH_BIT5 = 8'h20;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [IDX_W-1:0] timer_index;
        logic [7:0]       load_value;
    } mrtb_in_t;

    typedef struct packed {
        logic [7:0]  timer_value;
        logic [7:0]  expired_mask;
        logic        display_ready;
        logic        led_on;
        logic [7:0]  phase;
        logic [7:0]  long_phase;
        logic [31:0] tick_total;
    } mrtb_out_t;

    typedef struct packed {
        logic [7:0]                        phase;
        logic [7:0]                        long_phase;
        logic [NUM_TIMERS-1:0][TIMER_W-1:0] timers;
        logic [7:0]                        display_count;
        logic                              disp_ready;
        logic [7:0]                        hb_count;
        logic                              led;
        logic [31:0]                       tick_total;
    } mrtb_state_t;

    // one down-count step that stops at zero
    function automatic logic [TIMER_W-1:0] count_down(input logic [TIMER_W-1:0] v);
        logic [TIMER_W-1:0] r;
        r = (v != '0) ? v - TIMER_W'(1) : v;
        return r;
    endfunction

endpackage

@@ hdl/mrtb_step.sv @@
// next-state and result logic for one item of the timer bank
// depends on mrtb_pkg

module mrtb_step
    import mrtb_pkg::*;
(
    input  mrtb_state_t state_cur,
    input  mrtb_in_t    item,
    input  logic [7:0]  led_divide,
    input  logic [7:0]  hb_res_cur,
    output mrtb_state_t state_new,
    output logic [7:0]  hb_res_new,
    output mrtb_out_t   result
);

    logic [7:0]            ph;
    logic [7:0]            hb_inc;
    logic [7:0]            res_inc;
    logic                  hb_hit;
    logic [NUM_TIMERS-1:0] mask;

    always_comb
    begin
        state_new  = state_cur;
        hb_res_new = hb_res_cur;
        ph         = state_cur.phase + 8'd1;
        hb_inc     = state_cur.hb_count + 8'd1;
        // residue tracks hb_count modulo led_divide; a count wrap is always a hit
        res_inc    = hb_res_cur + 8'd1;
        hb_hit     = (hb_inc == 8'd0) || ((led_divide != 8'd0) && (res_inc == led_divide));

        unique case (item.cmd)
            CMD_TICK:
            begin
                state_new.phase      = ph;
                state_new.tick_total = state_cur.tick_total + 32'd1;
                if (ph == 8'd0)
                begin
                    state_new.long_phase = state_cur.long_phase + 8'd1;
                end
                state_new.timers[0] = count_down(state_cur.timers[0]);
                state_new.timers[1] = count_down(state_cur.timers[1]);
                priority if ((ph & PH_BIT0) != 8'd0)
                begin
                    // odd phases: nothing further
                end
                else if ((ph & PH_BIT1) != 8'd0)
                begin
                    state_new.timers[2] = count_down(state_cur.timers[2]);
                    state_new.timers[3] = count_down(state_cur.timers[3]);
                end
                else if ((ph & (PH_BIT2 | PH_BIT3)) != 8'd0)
                begin
                    // groups for bits 2 and 3 step no timers
                end
                else if ((ph & PH_BIT4) != 8'd0)
                begin
                    state_new.timers[4] = count_down(state_cur.timers[4]);
                    state_new.timers[5] = count_down(state_cur.timers[5]);
                end
                else if ((ph & PH_BIT5) != 8'd0)
                begin
                    state_new.timers[6] = count_down(state_cur.timers[6]);
                    state_new.timers[7] = count_down(state_cur.timers[7]);
                end
                else
                begin
                    // slow group: display countdown and heartbeat divider
                    state_new.display_count = state_cur.display_count - 8'd1;
                    if (state_cur.display_count == 8'd2)
                    begin
                        state_new.disp_ready = 1'b1;
                    end
                    if (hb_hit)
                    begin
                        state_new.hb_count = 8'd0;
                        state_new.led      = ~state_cur.led;
                        hb_res_new         = 8'd0;
                    end
                    else
                    begin
                        state_new.hb_count = hb_inc;
                        hb_res_new         = res_inc;
                    end
                end
            end
            CMD_LOAD:
            begin
                state_new.timers[item.timer_index] = item.load_value;
            end
            CMD_CLEAR:
            begin
                state_new.disp_ready = 1'b0;
            end
            CMD_READ:
            begin
                state_new = state_cur;
            end
            default:
            begin
                state_new = state_cur;
            end
        endcase

        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            mask[i] = (state_new.timers[i] == '0);
        end

        result.timer_value   = state_new.timers[item.timer_index];
        result.expired_mask  = mask;
        result.display_ready = state_new.disp_ready;
        result.led_on        = state_new.led;
        result.phase         = state_new.phase;
        result.long_phase    = state_new.long_phase;
        result.tick_total    = state_new.tick_total;
    end

endmodule

@@ hdl/multi_rate_timer_bank.sv @@
// top level of the tick-driven timer bank: input register, update, result register
// depends on mrtb_pkg and mrtb_step
//
// Eight 8-bit down-timers that stop at zero, driven by tick items through a phase counter
// with a long phase, a display countdown with ready flag and a divided heartbeat LED; other
// items load a timer, clear the display flag or just read. One item per clock is taken while
// in_stall is low and one result is given per item: the item lands in an input register, and
// all its state update happens in one pass into the result register when that is free or
// being emptied; the result leaves when out_stall is low. The heartbeat divider keeps the
// count modulo led_divide in a residue register, so a slow tick needs only an increment and
// a compare. led_divide resets to 78 and is written through cfg_wr_en/cfg_wr_data; the user
// must write it only while no item is in flight, which the block does not enforce. Each write
// runs a restoring pass over the eight count bits to rebuild the residue from the heartbeat
// count, stalling the input until it ends. There is no clearing pass after reset.

module multi_rate_timer_bank
    import mrtb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  mrtb_in_t   in_item,
    output logic       out_valid,
    input  logic       out_stall,
    output mrtb_out_t  out_item,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);

    logic        in_vld_reg,  in_vld_next;
    mrtb_in_t    in_item_reg;
    logic        out_vld_reg, out_vld_next;
    mrtb_out_t   out_item_reg;
    mrtb_state_t state_reg;
    mrtb_state_t state_next;
    mrtb_out_t   result_next;
    logic [7:0]  led_divide_reg;
    logic [7:0]  hb_res_reg;
    logic [7:0]  hb_res_next;
    logic        rc_busy_reg;
    logic [2:0]  rc_bit_reg;
    logic [7:0]  rc_rem_reg;
    logic [8:0]  rc_trial;
    logic [8:0]  rc_diff;
    logic        proc_go;
    logic        in_accept;

    mrtb_step u_step (
        .state_cur  (state_reg),
        .item       (in_item_reg),
        .led_divide (led_divide_reg),
        .hb_res_cur (hb_res_reg),
        .state_new  (state_next),
        .hb_res_new (hb_res_next),
        .result     (result_next)
    );

    // the held item moves on when the result register is free or being emptied
    assign proc_go   = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall  = (in_vld_reg && !proc_go) || rc_busy_reg;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_vld_reg;
    assign out_item  = out_item_reg;

    // residue rebuild: bring down one count bit per cycle, subtract the divide when it fits
    assign rc_trial = {rc_rem_reg, state_reg.hb_count[rc_bit_reg]};
    assign rc_diff  = (rc_trial >= {1'b0, led_divide_reg})
                      ? rc_trial - {1'b0, led_divide_reg} : rc_trial;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (proc_go)
        begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (proc_go)
        begin
            out_vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            state_reg      <= '0;
            led_divide_reg <= LED_DIVIDE_RESET;
            hb_res_reg     <= '0;
            rc_busy_reg    <= 1'b0;
            rc_bit_reg     <= '0;
            rc_rem_reg     <= '0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (proc_go)
            begin
                state_reg  <= state_next;
                hb_res_reg <= hb_res_next;
            end
            else if (rc_busy_reg && (rc_bit_reg == 3'd0))
            begin
                hb_res_reg <= rc_diff[7:0];
            end
            if (cfg_wr_en)
            begin
                led_divide_reg <= cfg_wr_data;
                rc_busy_reg    <= 1'b1;
                rc_bit_reg     <= 3'd7;
                rc_rem_reg     <= '0;
            end
            else if (rc_busy_reg)
            begin
                rc_rem_reg <= rc_diff[7:0];
                rc_bit_reg <= rc_bit_reg - 3'd1;
                if (rc_bit_reg == 3'd0)
                begin
                    rc_busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_item_reg <= in_item;
        end
        if (proc_go)
        begin
            out_item_reg <= result_next;
        end
    end

`ifndef SYNTHESIS
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !proc_go |=> $stable(state_reg))
        else $error("state changed without an item being processed");

    a_tick_count: assert property (@(posedge clk) disable iff (!rst_n)
        proc_go && (in_item_reg.cmd == CMD_TICK)
        |=> state_reg.tick_total == $past(state_reg.tick_total) + 32'd1)
        else $error("tick total did not advance on a tick");

    a_phase_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        proc_go && (in_item_reg.cmd == CMD_TICK) && (state_reg.phase == 8'hFF)
        |=> state_reg.long_phase == $past(state_reg.long_phase) + 8'd1)
        else $error("long phase missed a phase wrap");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        proc_go |=> out_vld_reg && (out_item_reg.tick_total == state_reg.tick_total))
        else $error("result register does not match the updated state");
`endif

endmodule
